FILE: rtl/drl_pkg.sv
// drl_pkg: shared types, constants and helpers for the dense relu layer
// no dependencies; used by drl_mac and dense_relu_layer_forward
package drl_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned OUT_W   = 15;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned CFG_W   = 1;
  localparam int unsigned PROD_W  = 2 * VAL_W;
  localparam int unsigned FRAC_W  = 8;

  localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
  localparam logic [OP_W-1:0] OP_BIAS   = 2'd1;
  localparam logic [OP_W-1:0] OP_ACT    = 2'd2;

  localparam logic [CFG_W-1:0] CFG_INPUT_COUNT  = 1'd0;
  localparam logic [CFG_W-1:0] CFG_OUTPUT_COUNT = 1'd1;

  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

  typedef struct packed {
    logic             first;
    logic             tail;
    logic             last;
    logic [IDX_W-1:0] idx;
  } mac_tag_t;

  function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] c, int unsigned maxv);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (32'(c) > maxv) begin
      r = CNT_W'(maxv);
    end
    return r;
  endfunction

endpackage

FILE: rtl/drl_ram.sv
// drl_ram: generic single write port, single read port ram
// registered read data; no dependencies
module drl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/drl_mac.sv
// drl_mac: multiply, accumulate, relu and saturation pipeline
// depends on drl_pkg; operands arrive in the cycle after the tag
module drl_mac #(
  parameter int unsigned MAX_INPUTS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       issue_i,
  input  drl_pkg::mac_tag_t          tag_i,
  input  logic signed [drl_pkg::VAL_W-1:0] weight_i,
  input  logic signed [drl_pkg::VAL_W-1:0] act_i,
  input  logic signed [drl_pkg::VAL_W-1:0] bias_i,
  output logic                       busy_o,
  output logic                       out_valid_o,
  output logic [drl_pkg::IDX_W-1:0]  out_index_o,
  output logic [drl_pkg::OUT_W-1:0]  out_value_o,
  output logic                       last_o
);

  localparam int unsigned ACC_W = drl_pkg::PROD_W + $clog2(MAX_INPUTS + 1);
  localparam int unsigned SAT_LO = drl_pkg::FRAC_W + drl_pkg::OUT_W;

  logic                                v1_q, v2_q, v3_q;
  drl_pkg::mac_tag_t                   t1_q, t2_q, t3_q;
  logic signed [drl_pkg::PROD_W-1:0]   prod_d, prod_q;
  logic signed [drl_pkg::VAL_W-1:0]    bias_q;
  logic signed [ACC_W-1:0]             acc_d, acc_q;
  logic [drl_pkg::OUT_W-1:0]           res_d;

  assign prod_d = weight_i * act_i;

  always_comb begin
    if (t2_q.first) begin
      acc_d = (ACC_W'(bias_q) <<< drl_pkg::FRAC_W) + ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_comb begin
    if (acc_q[ACC_W-1] || acc_q == '0) begin
      res_d = '0;
    end else if (|acc_q[ACC_W-2:SAT_LO]) begin
      res_d = '1;
    end else begin
      res_d = acc_q[SAT_LO-1:drl_pkg::FRAC_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      v1_q        <= issue_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q && t2_q.tail;
      out_valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q   <= tag_i;
    t2_q   <= t1_q;
    prod_q <= prod_d;
    bias_q <= bias_i;
    if (v2_q) begin
      acc_q <= acc_d;
      t3_q  <= t2_q;
    end
    out_index_o <= t3_q.idx;
    out_value_o <= res_d;
    last_o      <= t3_q.last;
  end

  assign busy_o = v1_q | v2_q | v3_q;

endmodule

FILE: rtl/dense_relu_layer_forward.sv
// dense_relu_layer_forward: fully connected q8.8 layer with relu, top level
// depends on drl_pkg, drl_ram and drl_mac
// weight, bias and non-final activation items are accepted whenever busy is low
// the final activation keeps busy high while the single mac runs through every input of every neuron;
// one result strobe then follows per neuron, in neuron index order
// results cannot be stalled; reset clears control and sets both counts to 16, memories are not cleared
module dense_relu_layer_forward #(
  parameter int unsigned MAX_INPUTS  = 16,
  parameter int unsigned MAX_OUTPUTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              cfg_we_i,
  input  logic [drl_pkg::CFG_W-1:0]         cfg_index_i,
  input  logic [drl_pkg::CNT_W-1:0]         cfg_data_i,
  input  logic [drl_pkg::OP_W-1:0]          op_i,
  input  logic [drl_pkg::IDX_W-1:0]         neuron_index_i,
  input  logic [drl_pkg::IDX_W-1:0]         input_index_i,
  input  logic signed [drl_pkg::VAL_W-1:0]  input_value_i,
  output logic                              out_valid_o,
  output logic [drl_pkg::IDX_W-1:0]         out_index_o,
  output logic [drl_pkg::OUT_W-1:0]         out_value_o,
  output logic                              last_o
);

  localparam int unsigned IW    = MAX_INPUTS > 1 ? $clog2(MAX_INPUTS) : 1;
  localparam int unsigned OW    = MAX_OUTPUTS > 1 ? $clog2(MAX_OUTPUTS) : 1;
  localparam int unsigned WDEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int unsigned WW    = WDEPTH > 1 ? $clog2(WDEPTH) : 1;

  logic [drl_pkg::CNT_W-1:0] in_cnt_q, out_cnt_q;
  logic [drl_pkg::CNT_W-1:0] nin, nout;
  logic                      run_q;
  logic [IW-1:0]             j_q;
  logic [OW-1:0]             n_q;
  logic                      accept, row_ok, col_ok, trigger, tail, last_n, mac_busy;
  drl_pkg::mac_tag_t         tag;
  logic signed [drl_pkg::VAL_W-1:0] w_rdata, a_rdata, b_rdata;

  assign nin  = drl_pkg::clamp_count(in_cnt_q, MAX_INPUTS);
  assign nout = drl_pkg::clamp_count(out_cnt_q, MAX_OUTPUTS);

  assign busy_o  = run_q | mac_busy;
  assign accept  = start_i && !busy_o;
  assign row_ok  = 32'(neuron_index_i) < MAX_OUTPUTS;
  assign col_ok  = 32'(input_index_i) < MAX_INPUTS;
  assign trigger = accept && op_i == drl_pkg::OP_ACT && col_ok
                   && 32'(input_index_i) == 32'(nin) - 32'd1;

  assign tail   = 32'(j_q) == 32'(nin) - 32'd1;
  assign last_n = 32'(n_q) == 32'(nout) - 32'd1;

  always_comb begin
    tag.first = j_q == '0;
    tag.tail  = tail;
    tag.last  = last_n;
    tag.idx   = drl_pkg::IDX_W'(32'(n_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= drl_pkg::COUNT_RESET;
      out_cnt_q <= drl_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        drl_pkg::CFG_INPUT_COUNT:  in_cnt_q  <= cfg_data_i;
        drl_pkg::CFG_OUTPUT_COUNT: out_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      j_q   <= '0;
      n_q   <= '0;
    end else if (trigger) begin
      run_q <= 1'b1;
      j_q   <= '0;
      n_q   <= '0;
    end else if (run_q) begin
      if (tail) begin
        j_q <= '0;
        if (last_n) begin
          run_q <= 1'b0;
        end else begin
          n_q <= n_q + OW'(1);
        end
      end else begin
        j_q <= j_q + IW'(1);
      end
    end
  end

  drl_ram #(
    .WIDTH (drl_pkg::VAL_W),
    .DEPTH (WDEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (accept && op_i == drl_pkg::OP_WEIGHT && row_ok && col_ok),
    .waddr_i (WW'(32'(neuron_index_i) * MAX_INPUTS + 32'(input_index_i))),
    .wdata_i (input_value_i),
    .raddr_i (WW'(32'(n_q) * MAX_INPUTS + 32'(j_q))),
    .rdata_o (w_rdata)
  );

  drl_ram #(
    .WIDTH (drl_pkg::VAL_W),
    .DEPTH (MAX_OUTPUTS)
  ) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (accept && op_i == drl_pkg::OP_BIAS && row_ok),
    .waddr_i (OW'(32'(neuron_index_i))),
    .wdata_i (input_value_i),
    .raddr_i (n_q),
    .rdata_o (b_rdata)
  );

  drl_ram #(
    .WIDTH (drl_pkg::VAL_W),
    .DEPTH (MAX_INPUTS)
  ) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (accept && op_i == drl_pkg::OP_ACT && col_ok),
    .waddr_i (IW'(32'(input_index_i))),
    .wdata_i (input_value_i),
    .raddr_i (j_q),
    .rdata_o (a_rdata)
  );

  drl_mac #(
    .MAX_INPUTS (MAX_INPUTS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (run_q),
    .tag_i       (tag),
    .weight_i    (w_rdata),
    .act_i       (a_rdata),
    .bias_i      (b_rdata),
    .busy_o      (mac_busy),
    .out_valid_o (out_valid_o),
    .out_index_o (out_index_o),
    .out_value_o (out_value_o),
    .last_o      (last_o)
  );

endmodule

FILE: dv/tb_dense_relu_layer_forward.sv
// tb_dense_relu_layer_forward: self-checking testbench for the dense relu layer
// sends weight, bias and activation items, predicts every neuron result and checks it
// depends on drl_pkg and dense_relu_layer_forward
`timescale 1ns / 1ps

module tb_dense_relu_layer_forward;

  localparam int unsigned NUM_IN      = 16;
  localparam int unsigned NUM_OUT     = 16;
  localparam logic [drl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 500;
  localparam int unsigned PHASE_ITEMS = 10;

  typedef struct packed {
    logic [drl_pkg::IDX_W-1:0] idx;
    logic [drl_pkg::OUT_W-1:0] value;
    logic                      last;
  } neuron_result_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             start_i;
  logic                             busy_o;
  logic                             cfg_we_i;
  logic [drl_pkg::CFG_W-1:0]        cfg_index_i;
  logic [drl_pkg::CNT_W-1:0]        cfg_data_i;
  logic [drl_pkg::OP_W-1:0]         op_i;
  logic [drl_pkg::IDX_W-1:0]        neuron_index_i;
  logic [drl_pkg::IDX_W-1:0]        input_index_i;
  logic signed [drl_pkg::VAL_W-1:0] input_value_i;
  logic                             out_valid_o;
  logic [drl_pkg::IDX_W-1:0]        out_index_o;
  logic [drl_pkg::OUT_W-1:0]        out_value_o;
  logic                             last_o;

  dense_relu_layer_forward #(
    .MAX_INPUTS (NUM_IN),
    .MAX_OUTPUTS(NUM_OUT)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (op_i),
    .neuron_index_i(neuron_index_i),
    .input_index_i (input_index_i),
    .input_value_i (input_value_i),
    .out_valid_o   (out_valid_o),
    .out_index_o   (out_index_o),
    .out_value_o   (out_value_o),
    .last_o        (last_o)
  );

  logic signed [drl_pkg::VAL_W-1:0] weight_mem [NUM_OUT][NUM_IN];
  logic signed [drl_pkg::VAL_W-1:0] bias_mem [NUM_OUT];
  logic signed [drl_pkg::VAL_W-1:0] act_mem [NUM_IN];
  bit                               weight_set [NUM_OUT][NUM_IN];
  bit                               bias_set [NUM_OUT];
  bit                               act_set [NUM_IN];
  logic [drl_pkg::CNT_W-1:0]        in_count_reg;
  logic [drl_pkg::CNT_W-1:0]        out_count_reg;
  neuron_result_t                   pending_neurons [$];
  int unsigned                      idle_pct;
  int unsigned                      items_sent;
  int unsigned                      fail_count;
  int unsigned                      quiet_cycles;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int unsigned active_count(logic [drl_pkg::CNT_W-1:0] c,
                                               int unsigned maxv);
    if (c == '0) return 1;
    if (int'(c) > maxv) return maxv;
    return int'(c);
  endfunction

  function automatic logic signed [drl_pkg::VAL_W-1:0] rand_value();
    int v;
    case ($urandom_range(3))
      0: return drl_pkg::VAL_W'($urandom);
      1: begin
        case ($urandom_range(4))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'sh0001;
          default: return 16'shffff;
        endcase
      end
      default: begin
        v = int'($urandom_range(1023)) - 512;
        return drl_pkg::VAL_W'(v);
      end
    endcase
  endfunction

  // one result per neuron, q16.16 sum back to unsigned q7.8 with relu and saturation
  task automatic compute_layer_outputs();
    int unsigned    n_in;
    int unsigned    n_out;
    longint         acc;
    neuron_result_t r;
    n_in  = active_count(in_count_reg, NUM_IN);
    n_out = active_count(out_count_reg, NUM_OUT);
    for (int n = 0; n < n_out; n++) begin
      acc = longint'(bias_mem[n]) * 256;
      for (int j = 0; j < n_in; j++) begin
        acc += longint'(weight_mem[n][j]) * longint'(act_mem[j]);
      end
      r.idx = drl_pkg::IDX_W'(n);
      if (acc <= 0) begin
        r.value = '0;
      end else if ((acc >>> 8) > 32767) begin
        r.value = '1;
      end else begin
        r.value = drl_pkg::OUT_W'(acc >>> 8);
      end
      r.last = (n == n_out - 1);
      pending_neurons.push_back(r);
    end
  endtask

  task automatic predict_item(input logic [drl_pkg::OP_W-1:0] op,
                              input logic [drl_pkg::IDX_W-1:0] row,
                              input logic [drl_pkg::IDX_W-1:0] col,
                              input logic signed [drl_pkg::VAL_W-1:0] value);
    case (op)
      drl_pkg::OP_WEIGHT: begin
        weight_mem[row][col] = value;
        weight_set[row][col] = 1'b1;
      end
      drl_pkg::OP_BIAS: begin
        bias_mem[row] = value;
        bias_set[row] = 1'b1;
      end
      drl_pkg::OP_ACT: begin
        act_mem[col] = value;
        act_set[col] = 1'b1;
        if (int'(col) == active_count(in_count_reg, NUM_IN) - 1) compute_layer_outputs();
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [drl_pkg::OP_W-1:0] op,
                           input logic [drl_pkg::IDX_W-1:0] row,
                           input logic [drl_pkg::IDX_W-1:0] col,
                           input logic signed [drl_pkg::VAL_W-1:0] value);
    start_i        <= 1'b1;
    op_i           <= op;
    neuron_index_i <= row;
    input_index_i  <= col;
    input_value_i  <= value;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_item(op, row, col, value);
    if (op != OP_UNUSED) items_sent++;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_neurons.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_counts(input logic [drl_pkg::CNT_W-1:0] n_in,
                            input logic [drl_pkg::CNT_W-1:0] n_out);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= drl_pkg::CFG_INPUT_COUNT;
    cfg_data_i  <= n_in;
    @(posedge clk_i);
    in_count_reg = n_in;
    cfg_index_i <= drl_pkg::CFG_OUTPUT_COUNT;
    cfg_data_i  <= n_out;
    @(posedge clk_i);
    out_count_reg = n_out;
    cfg_we_i <= 1'b0;
  endtask

  // stray writes, unused op, activations that never complete a vector
  task automatic send_noise();
    logic [drl_pkg::IDX_W-1:0] col;
    col = drl_pkg::IDX_W'($urandom);
    if (int'(col) == active_count(in_count_reg, NUM_IN) - 1) col = col + 1'b1;
    case ($urandom_range(3))
      0: send_item(drl_pkg::OP_WEIGHT, drl_pkg::IDX_W'($urandom), drl_pkg::IDX_W'($urandom),
                   rand_value());
      1: send_item(drl_pkg::OP_BIAS, drl_pkg::IDX_W'($urandom), drl_pkg::IDX_W'($urandom),
                   rand_value());
      2: send_item(drl_pkg::OP_ACT, drl_pkg::IDX_W'($urandom), col, rand_value());
      default: send_item(OP_UNUSED, drl_pkg::IDX_W'($urandom), drl_pkg::IDX_W'($urandom),
                         drl_pkg::VAL_W'($urandom));
    endcase
  endtask

  // fills whatever the current shape still needs, refreshes some entries, then fires
  task automatic load_vector();
    int unsigned n_in;
    int unsigned n_out;
    n_in  = active_count(in_count_reg, NUM_IN);
    n_out = active_count(out_count_reg, NUM_OUT);
    for (int n = 0; n < n_out; n++) begin
      if (!bias_set[n] || $urandom_range(3) == 0) begin
        send_item(drl_pkg::OP_BIAS, drl_pkg::IDX_W'(n), drl_pkg::IDX_W'($urandom),
                  rand_value());
      end
    end
    for (int n = 0; n < n_out; n++) begin
      for (int j = 0; j < n_in; j++) begin
        if (!weight_set[n][j] || $urandom_range(7) == 0) begin
          send_item(drl_pkg::OP_WEIGHT, drl_pkg::IDX_W'(n), drl_pkg::IDX_W'(j), rand_value());
        end
      end
    end
    for (int j = 0; j < n_in - 1; j++) begin
      if (!act_set[j] || $urandom_range(1) == 0) begin
        send_item(drl_pkg::OP_ACT, drl_pkg::IDX_W'($urandom), drl_pkg::IDX_W'(j),
                  rand_value());
      end
    end
    if ($urandom_range(3) == 0) send_noise();
    send_item(drl_pkg::OP_ACT, drl_pkg::IDX_W'($urandom), drl_pkg::IDX_W'(n_in - 1),
              rand_value());
  endtask

  // counts left at reset: full 16 x 16 layer
  task automatic test_full_layer();
    load_vector();
    wait_idle();
  endtask

  task automatic test_corner_values();
    set_counts(drl_pkg::CNT_W'(0), drl_pkg::CNT_W'(0));
    send_item(drl_pkg::OP_WEIGHT, 4'h0, 4'h0, 16'sh7fff);
    send_item(drl_pkg::OP_BIAS, 4'h0, 4'h0, 16'sh7fff);
    send_item(drl_pkg::OP_ACT, 4'h0, 4'h0, 16'sh7fff);
    send_item(drl_pkg::OP_WEIGHT, 4'h0, 4'h0, 16'sh0001);
    send_item(drl_pkg::OP_BIAS, 4'h0, 4'h0, 16'sh0000);
    send_item(drl_pkg::OP_ACT, 4'h0, 4'h0, 16'sh0001);
    send_item(drl_pkg::OP_ACT, 4'h0, 4'h0, 16'sh8000);
    send_item(drl_pkg::OP_WEIGHT, 4'h0, 4'h0, 16'sh8000);
    send_item(drl_pkg::OP_ACT, 4'h0, 4'h0, 16'sh8000);
    send_item(OP_UNUSED, 4'hf, 4'hf, 16'shffff);
    send_item(drl_pkg::OP_ACT, 4'hf, 4'h5, 16'sh0100);
    send_item(drl_pkg::OP_BIAS, 4'h0, 4'hf, 16'sh0100);
    send_item(drl_pkg::OP_WEIGHT, 4'h0, 4'h0, 16'sh0000);
    send_item(drl_pkg::OP_ACT, 4'h0, 4'h0, 16'sh1234);
    wait_idle();
    // counts above the store size act as the maximum
    set_counts(drl_pkg::CNT_W'(31), drl_pkg::CNT_W'(17));
    send_item(drl_pkg::OP_ACT, 4'h0, 4'hf, 16'sh7fff);
    wait_idle();
  endtask

  task automatic test_random_phase(input int unsigned pct);
    int unsigned first_item;
    idle_pct   = pct;
    first_item = items_sent;
    while (items_sent - first_item < PHASE_ITEMS) begin
      case ($urandom_range(7))
        0: set_counts(drl_pkg::CNT_W'(1), drl_pkg::CNT_W'(1));
        1: set_counts(drl_pkg::CNT_W'(16), drl_pkg::CNT_W'($urandom_range(1, 3)));
        2: set_counts(drl_pkg::CNT_W'($urandom_range(1, 3)), drl_pkg::CNT_W'(16));
        3: set_counts(drl_pkg::CNT_W'($urandom), drl_pkg::CNT_W'($urandom));
        default: set_counts(drl_pkg::CNT_W'($urandom_range(1, 6)),
                            drl_pkg::CNT_W'($urandom_range(1, 6)));
      endcase
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 2)) send_noise();
        load_vector();
      end
      wait_idle();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    neuron_result_t want;
    if (out_valid_o === 1'b1) begin
      if (pending_neurons.size() == 0) begin
        $display("%0t: unexpected result, expected none actual index %0d value %0d last %0b",
                 $time, out_index_o, out_value_o, last_o);
        fail_count++;
      end else begin
        want = pending_neurons.pop_front();
        check_field("out_index", 16'(want.idx), 16'(out_index_o));
        check_field("out_value", 16'(want.value), 16'(out_value_o));
        check_field("last", 16'(want.last), 16'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((start_i === 1'b1 && busy_o === 1'b0) || out_valid_o === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dense_relu_layer_forward test failed");
      $finish;
    end
  end

  initial begin
    idle_pct      = 26;
    items_sent    = 0;
    fail_count    = 0;
    quiet_cycles  = 0;
    in_count_reg  = drl_pkg::COUNT_RESET;
    out_count_reg = drl_pkg::COUNT_RESET;
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= drl_pkg::CFG_INPUT_COUNT;
    cfg_data_i     <= '0;
    op_i           <= drl_pkg::OP_WEIGHT;
    neuron_index_i <= '0;
    input_index_i  <= '0;
    input_value_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_layer();
    test_corner_values();
    test_random_phase(26);
    test_random_phase(58);
    test_random_phase(0);
    wait_idle();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("dense_relu_layer_forward test passed");
    end else begin
      $display("dense_relu_layer_forward test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/drl_pkg.sv
rtl/drl_ram.sv
rtl/drl_mac.sv
rtl/dense_relu_layer_forward.sv
dv/tb_dense_relu_layer_forward.sv
